// File: hw/rtl/fpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared constants and controller/datapath interface types for the
// position cache.
// ----------------------------------------------------------------------------
package fpc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
	localparam int POS_W   = 64;
	localparam int SLOT_W  = 4;
	localparam int IN_W    = 3 * POS_W;
	localparam int OUT_W   = 8;
	localparam int CAP_RESET = 16;

	typedef struct packed {
		logic capture;
		logic compare;
		logic update;
	} fpc_cmd_t;

	typedef struct packed {
		logic out_free;
	} fpc_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/fpc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_ctrl
// Sequencer: accept a request, compare tags, then resolve and update.
// ----------------------------------------------------------------------------
module fpc_ctrl import fpc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire fpc_sts_t sts,
	output fpc_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MATCH  = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.compare = 1'b0;
		cmd.update  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.compare = 1'b1;
				state_d     = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (sts.out_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/fpc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_dp
// Tag store, parallel compare, fill/evict bookkeeping and output register.
// ----------------------------------------------------------------------------
module fpc_dp import fpc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fpc_cmd_t         cmd,
	output fpc_sts_t              sts,
	input  wire logic [IN_W-1:0]  req,
	input  wire logic [CAP_W-1:0] cap,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OUT_W-1:0]      out_data
);

	logic [POS_W-1:0] req_x_q, req_y_q, req_z_q;
	logic [POS_W-1:0] tag_x_q [ENTRIES];
	logic [POS_W-1:0] tag_y_q [ENTRIES];
	logic [POS_W-1:0] tag_z_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] match_q;
	logic [CNT_W-1:0]   fill_q;
	logic [IDX_W-1:0]   oldest_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               hit;
	logic [IDX_W-1:0]   hit_idx;
	logic [CNT_W-1:0]   eff_cap;
	logic [IDX_W-1:0]   evict_idx;
	logic [CNT_W-1:0]   next_old;
	logic               fill_free;
	logic [IDX_W-1:0]   slot_idx;
	logic [SLOT_W-1:0]  slot_out;

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;

	// lowest matching entry
	always_comb begin
		hit     = |match_q;
		hit_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		if (cap == '0) begin
			eff_cap = CNT_W'(1);
		end else if (CMP_W'(cap) > CMP_W'(ENTRIES)) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap);
		end
	end

	always_comb begin
		fill_free = (fill_q < eff_cap);
		evict_idx = (CNT_W'(oldest_q) >= fill_q) ? '0 : oldest_q;
		next_old  = CNT_W'(evict_idx) + CNT_W'(1);
		if (hit) begin
			slot_idx = hit_idx;
		end else if (fill_free) begin
			slot_idx = IDX_W'(fill_q);
		end else begin
			slot_idx = evict_idx;
		end
		for (int b = 0; b < SLOT_W; b++) begin
			slot_out[b] = (b < IDX_W) ? slot_idx[b % IDX_W] : 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_x_q <= req[POS_W-1:0];
			req_y_q <= req[2*POS_W-1:POS_W];
			req_z_q <= req[3*POS_W-1:2*POS_W];
		end
		if (cmd.compare) begin
			for (int i = 0; i < ENTRIES; i++) begin
				match_q[i] <= valid_q[i] && (tag_x_q[i] == req_x_q)
					&& (tag_y_q[i] == req_y_q) && (tag_z_q[i] == req_z_q);
			end
		end
		if (cmd.update) begin
			out_data_q <= {{(OUT_W - SLOT_W - 2){1'b0}}, !hit && !fill_free, slot_out, hit};
			if (!hit) begin
				tag_x_q[slot_idx] <= req_x_q;
				tag_y_q[slot_idx] <= req_y_q;
				tag_z_q[slot_idx] <= req_z_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fill_q      <= '0;
			oldest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				out_valid_q <= 1'b1;
				if (!hit) begin
					valid_q[slot_idx] <= 1'b1;
					if (fill_free) begin
						fill_q <= fill_q + CNT_W'(1);
					end else begin
						oldest_q <= (next_old >= fill_q) ? '0 : IDX_W'(next_old);
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/fifo_position_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_position_cache
// Fully associative cache of 3-D signed positions with FIFO replacement.
//
// Requests arrive on the s_t* stream (x, y, z positions); one result per
// request leaves on the m_t* stream: hit flag, slot index and evicted flag.
// A hit returns the matching slot. A miss fills the next free slot while
// fewer than capacity_in_use slots are in use, else it evicts the oldest
// inserted entry and reuses its slot.
// The transfer edge captures the request, then tag compare across all
// entries is registered, then resolve and update load the output
// register. The controller takes no new request until the last one has
// passed its capture/compare/update sequence. A new request is taken
// while a result still waits.
// A stalled m_tready holds the result in the output register; the next
// request then waits in the update step until that result is taken.
// Reset clears all valid marks, the fill count and the eviction pointer
// at once; capacity_in_use returns to 16. The APB port holds the single
// register capacity_in_use at address 0.
// ----------------------------------------------------------------------------
module fifo_position_cache import fpc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // pos_x, pos_y, pos_z
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // hit, slot[3:0], evicted, pad
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam logic REG_CAPACITY = 1'b0;

	logic [CAP_W-1:0] cap_q;
	fpc_cmd_t         cmd;
	fpc_sts_t         sts;

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_CAPACITY: prdata = {{(32 - CAP_W){1'b0}}, cap_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RESET);
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	fpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (s_tdata),
		.cap       (cap_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO-replacement position cache. A short
// directed table covers extreme positions, hits, single-coordinate misses
// and capacity values below, at and beyond the legal range. Random lookups
// then draw mostly from a small pool of recent positions so that hits,
// fills and evictions all occur, under several capacity settings and with
// random gaps on both streams. Every result is checked against the row's
// expected value if given, else a cycle-free cache predictor in the bench.
// ----------------------------------------------------------------------------
module tb_top import fpc_pkg::*; ();

	localparam logic [2:0]       CAP_ADDR  = 3'd0;
	localparam int               SEG_ITEMS = 62;
	localparam int               NUM_SEGS  = 8;
	localparam int               POOL_N    = 24;
	localparam int               PEND_N    = 16;
	localparam logic [POS_W-1:0] MAXP      = 64'h7fff_ffff_ffff_ffff;
	localparam logic [POS_W-1:0] MINP      = 64'h8000_0000_0000_0000;
	localparam logic [POS_W-1:0] ONES      = '1;

	typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
	} lookup_res_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CAP_W-1:0] cap;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
		logic             known;
		lookup_res_t      res;
	} dir_row_t;

	localparam lookup_res_t NO_RES = '0;
	localparam int          DIR_N  = 24;

	dir_row_t dir_tab [DIR_N] = '{
		'{ROW_REQ, 5'd0, 64'd0, 64'd0, 64'd0, 1'b1, '{1'b0, 4'd0, 1'b0}},
		'{ROW_REQ, 5'd0, MAXP,  MAXP,  MAXP,  1'b1, '{1'b0, 4'd1, 1'b0}},
		'{ROW_REQ, 5'd0, MINP,  MINP,  MINP,  1'b1, '{1'b0, 4'd2, 1'b0}},
		'{ROW_REQ, 5'd0, 64'd0, 64'd0, 64'd0, 1'b1, '{1'b1, 4'd0, 1'b0}},
		'{ROW_REQ, 5'd0, MAXP,  MINP,  64'd0, 1'b1, '{1'b0, 4'd3, 1'b0}},
		'{ROW_REQ, 5'd0, 64'd0, 64'd0, 64'd1, 1'b1, '{1'b0, 4'd4, 1'b0}},
		'{ROW_REQ, 5'd0, 64'd1, 64'd0, 64'd0, 1'b1, '{1'b0, 4'd5, 1'b0}},
		'{ROW_REQ, 5'd0, ONES,  ONES,  ONES,  1'b1, '{1'b0, 4'd6, 1'b0}},
		'{ROW_REQ, 5'd0, MAXP,  MAXP,  MAXP,  1'b1, '{1'b1, 4'd1, 1'b0}},
		// capacity below fill count: rotate over the slots in use
		'{ROW_CAP, 5'd2, 64'd0, 64'd0, 64'd0, 1'b0, NO_RES},
		'{ROW_REQ, 5'd0, 64'd5, 64'd5, 64'd5, 1'b1, '{1'b0, 4'd0, 1'b1}},
		'{ROW_REQ, 5'd0, 64'd0, 64'd0, 64'd0, 1'b0, NO_RES},
		'{ROW_REQ, 5'd0, MAXP,  MAXP,  MAXP,  1'b0, NO_RES},
		'{ROW_REQ, 5'd0, MINP,  MINP,  MINP,  1'b0, NO_RES},
		// zero acts as one
		'{ROW_CAP, 5'd0, 64'd0, 64'd0, 64'd0, 1'b0, NO_RES},
		'{ROW_REQ, 5'd0, 64'd7, 64'd7, 64'd7, 1'b0, NO_RES},
		'{ROW_REQ, 5'd0, 64'd7, 64'd7, 64'd7, 1'b0, NO_RES},
		// above the entry count acts as full size, free slots refill
		'{ROW_CAP, 5'd31, 64'd0, 64'd0, 64'd0, 1'b0, NO_RES},
		'{ROW_REQ, 5'd0, 64'd8, 64'd8, 64'd8, 1'b0, NO_RES},
		'{ROW_REQ, 5'd0, 64'd0, 64'd1, 64'd0, 1'b0, NO_RES},
		'{ROW_CAP, 5'd1, 64'd0, 64'd0, 64'd0, 1'b0, NO_RES},
		'{ROW_REQ, 5'd0, MINP,  MAXP,  ONES,  1'b0, NO_RES},
		'{ROW_CAP, 5'd16, 64'd0, 64'd0, 64'd0, 1'b0, NO_RES},
		'{ROW_REQ, 5'd0, 64'd9, 64'd9, 64'd9, 1'b0, NO_RES}
	};

	int unsigned send_idle_tab [4] = '{0, 63, 0, 35};
	int unsigned recv_stall_tab [4] = '{0, 0, 63, 35};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // pos_x, pos_y, pos_z
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;   // hit, slot[3:0], evicted, pad
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [2:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;

	// cache model state
	logic             line_valid [ENTRIES];
	logic [POS_W-1:0] cached_x [ENTRIES];
	logic [POS_W-1:0] cached_y [ENTRIES];
	logic [POS_W-1:0] cached_z [ENTRIES];
	int unsigned      fill_cnt;
	int unsigned      evict_ptr;
	int unsigned      cap_reg;

	// expected results in transfer order
	lookup_res_t      pend_mem [PEND_N];
	int unsigned      pend_wr = 0;
	int unsigned      pend_rd = 0;
	lookup_res_t      want_res;
	lookup_res_t      got_res;

	logic [POS_W-1:0] pool_x [POOL_N];
	logic [POS_W-1:0] pool_y [POOL_N];
	logic [POS_W-1:0] pool_z [POOL_N];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned n_fail    = 0;
	int unsigned n_sent    = 0;
	int unsigned n_hits    = 0;
	int unsigned n_evicts  = 0;
	int unsigned n_capwr   = 0;

	fifo_position_cache dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic lookup_res_t predict_lookup(input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
		lookup_res_t r;
		int unsigned lim;
		int unsigned s;
		r = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!r.hit && line_valid[i] && cached_x[i] == x && cached_y[i] == y &&
					cached_z[i] == z) begin
				r.hit  = 1'b1;
				r.slot = i[SLOT_W-1:0];
			end
		end
		if (!r.hit) begin
			lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
			if (fill_cnt < lim) begin
				s = fill_cnt;
				fill_cnt++;
			end else begin
				if (evict_ptr >= fill_cnt)
					evict_ptr = 0;
				s = evict_ptr;
				r.evicted = 1'b1;
				evict_ptr++;
				if (evict_ptr >= fill_cnt)
					evict_ptr = 0;
			end
			r.slot = s[SLOT_W-1:0];
			line_valid[s] = 1'b1;
			cached_x[s] = x;
			cached_y[s] = y;
			cached_z[s] = z;
		end
		return r;
	endfunction

	function automatic logic [POS_W-1:0] rand_coord();
		case ($urandom_range(9))
			0: return MAXP;
			1: return MINP;
			2: return '0;
			3: return ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_lookup(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [POS_W-1:0] z, input logic known, input lookup_res_t typed);
		lookup_res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_lookup(x, y, z);
		pend_mem[pend_wr % PEND_N] = known ? typed : r;
		pend_wr++;
		n_sent++;
	endtask

	task automatic drain_lookups();
		s_tvalid <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain_lookups();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= CAP_ADDR;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cap_reg = v;
		n_capwr++;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// result checker and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res.hit     = m_tdata[0];
				got_res.slot    = m_tdata[4:1];
				got_res.evicted = m_tdata[5];
				if (pend_wr == pend_rd) begin
					$error("result transfer with no lookup pending");
					n_fail++;
				end else begin
					want_res = pend_mem[pend_rd % PEND_N];
					pend_rd++;
					if (got_res.hit !== want_res.hit) begin
						$error("hit: expected %0d, got %0d", want_res.hit, got_res.hit);
						n_fail++;
					end
					if (got_res.slot !== want_res.slot) begin
						$error("slot: expected %0d, got %0d", want_res.slot, got_res.slot);
						n_fail++;
					end
					if (got_res.evicted !== want_res.evicted) begin
						$error("evicted: expected %0d, got %0d", want_res.evicted,
							got_res.evicted);
						n_fail++;
					end
					if (want_res.hit)
						n_hits++;
					if (want_res.evicted)
						n_evicts++;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("fifo_position_cache regression: fail");
		$finish;
	end

	initial begin
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
		int unsigned      r;
		int unsigned      k;
		int unsigned      b;
		logic [CAP_W-1:0] seg_cap;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		for (int i = 0; i < ENTRIES; i++)
			line_valid[i] = 1'b0;
		fill_cnt  = 0;
		evict_ptr = 0;
		cap_reg   = CAP_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CAP)
				write_capacity(dir_tab[i].cap);
			else
				send_lookup(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].known,
					dir_tab[i].res);
		end

		// random lookups over a pool of recent positions
		for (int i = 0; i < POOL_N; i++) begin
			pool_x[i] = rand_coord();
			pool_y[i] = rand_coord();
			pool_z[i] = rand_coord();
		end
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			case (seg)
				0: seg_cap = 5'd4;
				1: seg_cap = 5'd16;
				2: seg_cap = 5'd1;
				3: seg_cap = 5'd31;
				default: seg_cap = ($urandom_range(3) == 0) ? CAP_W'($urandom_range(31))
					: CAP_W'($urandom_range(16, 1));
			endcase
			write_capacity(seg_cap);
			send_idle_pct  = send_idle_tab[seg % 4];
			recv_stall_pct = recv_stall_tab[seg % 4];
			for (int n = 0; n < SEG_ITEMS; n++) begin
				// hold off until the cache has answered everything
				if (seg == 1 && n == SEG_ITEMS / 2)
					drain_lookups();
				r = $urandom_range(99);
				k = $urandom_range(POOL_N - 1);
				px = pool_x[k];
				py = pool_y[k];
				pz = pool_z[k];
				if (r >= 60 && r < 72) begin
					// near miss: one bit of one coordinate differs
					b = $urandom_range(POS_W - 1);
					case ($urandom_range(2))
						0: px[b] = ~px[b];
						1: py[b] = ~py[b];
						default: pz[b] = ~pz[b];
					endcase
				end else if (r >= 72) begin
					px = rand_coord();
					py = rand_coord();
					pz = rand_coord();
					pool_x[k] = px;
					pool_y[k] = py;
					pool_z[k] = pz;
				end
				send_lookup(px, py, pz, 1'b0, NO_RES);
			end
		end

		drain_lookups();
		repeat (10) @(posedge clk);
		$display("covered %0d lookups: %0d hits, %0d evictions", n_sent, n_hits, n_evicts);
		$display("across %0d capacity writes and four stall patterns", n_capwr);
		if (n_fail == 0)
			$display("fifo_position_cache regression: pass");
		else
			$display("fifo_position_cache regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

// File: fifo_position_cache.f
hw/rtl/fpc_pkg.sv
hw/rtl/fpc_ctrl.sv
hw/rtl/fpc_dp.sv
hw/rtl/fifo_position_cache.sv
bench/tb_top.sv
